// ===== rtl/csvcsa_pkg.sv =====
package csvcsa_pkg;

  // Field widths and fixed-point format
  localparam int FRAC_DIGITS     = 3;
  localparam int SUM_WIDTH       = 48;
  localparam int COUNT_WIDTH     = 32;
  localparam int FIELD_WIDTH     = 40;
  localparam int BYTE_WIDTH      = 8;
  localparam int COL_WIDTH       = 4;
  localparam int FRAC_CNT_WIDTH  = 3;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 8;
  localparam int DIV_CNT_WIDTH   = $clog2(SUM_WIDTH + 1);

  // Accumulator width: holds sum plus signed field value without overflow
  localparam int ACC_WIDTH = ((SUM_WIDTH > FIELD_WIDTH) ? SUM_WIDTH : FIELD_WIDTH) + 2;

  localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = {FIELD_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COL_WIDTH-1:0]   COMMAS_MAX = {COL_WIDTH{1'b1}};

  localparam logic signed [ACC_WIDTH-1:0] ACC_SUM_MAX =
    {{(ACC_WIDTH-SUM_WIDTH+1){1'b0}}, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_SUM_MIN =
    {{(ACC_WIDTH-SUM_WIDTH+1){1'b1}}, {(SUM_WIDTH-1){1'b0}}};

  // Register reset values
  localparam logic [COL_WIDTH-1:0] COLUMN_INDEX_RESET = 4'd2;
  localparam logic                 SKIP_HEADER_RESET  = 1'b1;

  // Character codes
  localparam logic [BYTE_WIDTH-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_WIDTH-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_WIDTH-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_WIDTH-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_WIDTH-1:0] CH_POINT   = 8'h2E;
  localparam logic [BYTE_WIDTH-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CH_NINE    = 8'h39;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COLUMN_INDEX = 4'd0,
    REG_SKIP_HEADER  = 4'd1
  } cfg_reg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic byte_accept;
    logic scale_step;
    logic commit;
    logic div_load;
    logic div_step;
    logic finish;
  } csvcsa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_commit;
    logic in_last;
    logic last_r;
    logic scale_more;
    logic div_done;
    logic out_free;
  } csvcsa_stat_t;

  // Multiply a field magnitude by ten, add a digit, saturate
  function automatic logic [FIELD_WIDTH-1:0] mul10_add(
    input logic [FIELD_WIDTH-1:0] f,
    input logic [3:0]             d
  );
    logic [FIELD_WIDTH+3:0] v;
    v = ({4'b0, f} << 3) + ({4'b0, f} << 1) + {{FIELD_WIDTH{1'b0}}, d};
    return (v > {4'b0, FIELD_MAX}) ? FIELD_MAX : v[FIELD_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/csvcsa_if.sv =====
interface csvcsa_in_if;
  import csvcsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BYTE_WIDTH-1:0] text_byte;
  logic                  end_of_text;
  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface csvcsa_out_if;
  import csvcsa_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [COUNT_WIDTH-1:0]      row_total;
  logic signed [SUM_WIDTH-1:0] value_sum;
  logic signed [SUM_WIDTH-1:0] value_mean;
  logic                        mean_valid;
  modport source (output valid, output row_total, output value_sum, output value_mean,
                  output mean_valid, input ready);
  modport sink   (input valid, input row_total, input value_sum, input value_mean,
                  input mean_valid, output ready);
endinterface

interface csvcsa_cfg_if;
  import csvcsa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/csv_column_sum_average.sv =====
// CSV column sum and average.
// in_ch takes one text byte per item with end_of_text on the last byte of a text.
// cfg_ch writes column_index (index 0) and skip_header (index 1); it is always
// ready and is meant to be written only while no text is in flight.
// out_ch gives one item per text: row count, saturated sum, mean truncated
// toward zero and a flag that is low when no data row was seen.
// Sequence: an ordinary byte is only accepted. A newline runs accept, then fraction
// scaling by ten one digit per cycle, then add.
// The last byte also runs the restoring divider, one quotient bit per cycle, before
// out_ch.valid rises; a row commit comes first when that byte closes a row.
// in_ch.ready is low while a row commit or the division runs.
// The result sits in an output register: the next text is accepted while it
// waits, and only a second result waits for out_ch.ready.
// Reset sets column_index to 2, skip_header to 1 and clears sum and count;
// after each result the stream state restarts the same way, registers kept.
module csv_column_sum_average (
  input logic          clk,
  input logic          rst_n,
  csvcsa_in_if.sink    in_ch,
  csvcsa_out_if.source out_ch,
  csvcsa_cfg_if.sink   cfg_ch
);
  import csvcsa_pkg::*;

  csvcsa_cmd_t  cmd;
  csvcsa_stat_t stat;
  logic         in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  csvcsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csvcsa_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_byte        (in_ch.text_byte),
    .in_last        (in_ch.end_of_text),
    .cfg_fire       (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_row_total  (out_ch.row_total),
    .out_value_sum  (out_ch.value_sum),
    .out_value_mean (out_ch.value_mean),
    .out_mean_valid (out_ch.mean_valid)
  );

endmodule

// ===== rtl/csvcsa_ctrl.sv =====
module csvcsa_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  csvcsa_pkg::csvcsa_stat_t stat,
  output csvcsa_pkg::csvcsa_cmd_t  cmd
);
  import csvcsa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCALE = 6'b000010,
    S_ADD   = 6'b000100,
    S_DIVLD = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence bytes, row commit, division and result hand-off
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.byte_accept = 1'b1;
          if (stat.need_commit) begin
            state_nxt = S_SCALE;
          end else if (stat.in_last) begin
            state_nxt = S_DIVLD;
          end
        end
      end
      S_SCALE: begin
        if (stat.scale_more) begin
          cmd.scale_step = 1'b1;
        end else begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        cmd.commit = 1'b1;
        state_nxt  = stat.last_r ? S_DIVLD : S_IDLE;
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/csvcsa_dp.sv =====
module csvcsa_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  csvcsa_pkg::csvcsa_cmd_t                 cmd,
  output csvcsa_pkg::csvcsa_stat_t                stat,
  input  logic [csvcsa_pkg::BYTE_WIDTH-1:0]       in_byte,
  input  logic                                    in_last,
  input  logic                                    cfg_fire,
  input  logic [csvcsa_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [csvcsa_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic [csvcsa_pkg::COUNT_WIDTH-1:0]      out_row_total,
  output logic signed [csvcsa_pkg::SUM_WIDTH-1:0] out_value_sum,
  output logic signed [csvcsa_pkg::SUM_WIDTH-1:0] out_value_mean,
  output logic                                    out_mean_valid
);
  import csvcsa_pkg::*;

  typedef enum logic [3:0] {
    PH_BEFORE = 4'b0001,
    PH_INT    = 4'b0010,
    PH_FRAC   = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Configuration registers
  logic [COL_WIDTH-1:0] col_r, col_nxt;
  logic                 skip_r, skip_nxt;

  // Stream and field state
  logic                      hp_r, hp_nxt;
  logic [COL_WIDTH-1:0]      commas_r, commas_nxt;
  phase_t                    phase_r, phase_nxt;
  logic                      neg_r, neg_nxt;
  logic [FIELD_WIDTH-1:0]    field_r, field_nxt;
  logic [FRAC_CNT_WIDTH-1:0] frac_r, frac_nxt;
  logic [SUM_WIDTH-1:0]      sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0]    count_r, count_nxt;
  logic                      row_open_r, row_open_nxt;
  logic                      last_r, last_nxt;

  // Divider
  logic [SUM_WIDTH-1:0]     quot_r, quot_nxt;
  logic [COUNT_WIDTH-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_WIDTH-1:0] div_cnt_r, div_cnt_nxt;
  logic                     div_neg_r, div_neg_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [COUNT_WIDTH-1:0]        row_total_r, row_total_nxt;
  logic signed [SUM_WIDTH-1:0]   value_sum_r, value_sum_nxt;
  logic signed [SUM_WIDTH-1:0]   value_mean_r, value_mean_nxt;
  logic                          mean_valid_r, mean_valid_nxt;

  // Combinational helpers
  logic                        is_digit;
  logic [3:0]                  digit_val;
  logic                        frac_room;
  logic signed [ACC_WIDTH-1:0] acc_val;
  logic signed [ACC_WIDTH-1:0] acc_sum;
  logic [COUNT_WIDTH:0]        div_trial;
  logic [SUM_WIDTH-1:0]        sum_mag;

  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit_val = 4'(in_byte - CH_ZERO);
  assign frac_room = (frac_r < FRAC_CNT_WIDTH'(FRAC_DIGITS));

  // Signed field value and saturating sum candidate
  assign acc_val = neg_r ? -$signed({{(ACC_WIDTH-FIELD_WIDTH){1'b0}}, field_r})
                         :  $signed({{(ACC_WIDTH-FIELD_WIDTH){1'b0}}, field_r});
  assign acc_sum = $signed({{(ACC_WIDTH-SUM_WIDTH){sum_r[SUM_WIDTH-1]}}, sum_r}) + acc_val;

  assign sum_mag   = sum_r[SUM_WIDTH-1] ? (~sum_r + 1'b1) : sum_r;
  assign div_trial = {rem_r, quot_r[SUM_WIDTH-1]};

  // Status to controller
  always_comb begin
    stat             = '0;
    stat.need_commit = hp_r ? (in_last && row_open_r)
                            : ((in_byte == CH_NEWLINE) || in_last);
    stat.in_last     = in_last;
    stat.last_r      = last_r;
    stat.scale_more  = frac_room;
    stat.div_done    = (div_cnt_r == DIV_CNT_WIDTH'(SUM_WIDTH));
    stat.out_free    = !out_valid_r || out_ready;
  end

  // Next-state logic for parser, accumulator, divider and output
  always_comb begin
    col_nxt        = col_r;
    skip_nxt       = skip_r;
    hp_nxt         = hp_r;
    commas_nxt     = commas_r;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    field_nxt      = field_r;
    frac_nxt       = frac_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    row_open_nxt   = row_open_r;
    last_nxt       = last_r;
    quot_nxt       = quot_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    div_neg_nxt    = div_neg_r;
    out_valid_nxt  = out_valid_r;
    row_total_nxt  = row_total_r;
    value_sum_nxt  = value_sum_r;
    value_mean_nxt = value_mean_r;
    mean_valid_nxt = mean_valid_r;

    // Parse one byte
    if (cmd.byte_accept) begin
      last_nxt = in_last;
      if (hp_r) begin
        if (in_byte == CH_NEWLINE) begin
          hp_nxt = 1'b0;
        end
      end else if (in_byte != CH_NEWLINE) begin
        row_open_nxt = 1'b1;
        if (in_byte == CH_COMMA) begin
          if (commas_r == col_r) begin
            phase_nxt = PH_DONE;
          end
          if (commas_r != COMMAS_MAX) begin
            commas_nxt = commas_r + 1'b1;
          end
        end else if (commas_r == col_r) begin
          unique case (phase_r)
            PH_BEFORE: begin
              priority if ((in_byte == CH_SPACE) || (in_byte == CH_TAB)) begin
                phase_nxt = PH_BEFORE;
              end else if ((in_byte == CH_PLUS) || (in_byte == CH_MINUS)) begin
                neg_nxt   = (in_byte == CH_MINUS);
                phase_nxt = PH_INT;
              end else if (is_digit) begin
                field_nxt = mul10_add(field_r, digit_val);
                phase_nxt = PH_INT;
              end else if (in_byte == CH_POINT) begin
                phase_nxt = PH_FRAC;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_INT: begin
              priority if (is_digit) begin
                field_nxt = mul10_add(field_r, digit_val);
              end else if (in_byte == CH_POINT) begin
                phase_nxt = PH_FRAC;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            PH_FRAC: begin
              if (is_digit) begin
                if (frac_room) begin
                  field_nxt = mul10_add(field_r, digit_val);
                  frac_nxt  = frac_r + 1'b1;
                end
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end

    // Scale the field up to the full fraction digit count
    if (cmd.scale_step) begin
      field_nxt = mul10_add(field_r, 4'd0);
      frac_nxt  = frac_r + 1'b1;
    end

    // Add the row to the sum and count, then drop the field
    if (cmd.commit) begin
      priority if (acc_sum > ACC_SUM_MAX) begin
        sum_nxt = ACC_SUM_MAX[SUM_WIDTH-1:0];
      end else if (acc_sum < ACC_SUM_MIN) begin
        sum_nxt = ACC_SUM_MIN[SUM_WIDTH-1:0];
      end else begin
        sum_nxt = acc_sum[SUM_WIDTH-1:0];
      end
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
      commas_nxt   = '0;
      phase_nxt    = PH_BEFORE;
      neg_nxt      = 1'b0;
      field_nxt    = '0;
      frac_nxt     = '0;
      row_open_nxt = 1'b0;
    end

    // Start the magnitude division
    if (cmd.div_load) begin
      quot_nxt    = sum_mag;
      rem_nxt     = '0;
      div_cnt_nxt = '0;
      div_neg_nxt = sum_r[SUM_WIDTH-1];
    end

    // One quotient bit per cycle
    if (cmd.div_step) begin
      if (div_trial >= {1'b0, count_r}) begin
        rem_nxt  = COUNT_WIDTH'(div_trial - {1'b0, count_r});
        quot_nxt = {quot_r[SUM_WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt  = div_trial[COUNT_WIDTH-1:0];
        quot_nxt = {quot_r[SUM_WIDTH-2:0], 1'b0};
      end
      div_cnt_nxt = div_cnt_r + 1'b1;
    end

    // Release a taken result
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Load the result and restart the stream
    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      row_total_nxt  = count_r;
      value_sum_nxt  = $signed(sum_r);
      mean_valid_nxt = (count_r != '0);
      if (count_r == '0) begin
        value_mean_nxt = '0;
      end else begin
        value_mean_nxt = div_neg_r ? $signed(-quot_r) : $signed(quot_r);
      end
      hp_nxt       = skip_r;
      sum_nxt      = '0;
      count_nxt    = '0;
      commas_nxt   = '0;
      phase_nxt    = PH_BEFORE;
      neg_nxt      = 1'b0;
      field_nxt    = '0;
      frac_nxt     = '0;
      row_open_nxt = 1'b0;
      last_nxt     = 1'b0;
    end

    // Register writes
    if (cfg_fire) begin
      unique case (cfg_index)
        REG_COLUMN_INDEX: begin
          col_nxt = cfg_data[COL_WIDTH-1:0];
        end
        REG_SKIP_HEADER: begin
          skip_nxt = cfg_data[0];
          hp_nxt   = cfg_data[0];
        end
        default: begin
          col_nxt = col_r;
        end
      endcase
    end
  end

  // Control and stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= COLUMN_INDEX_RESET;
      skip_r      <= SKIP_HEADER_RESET;
      hp_r        <= SKIP_HEADER_RESET;
      commas_r    <= '0;
      phase_r     <= PH_BEFORE;
      neg_r       <= 1'b0;
      field_r     <= '0;
      frac_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      row_open_r  <= 1'b0;
      last_r      <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      skip_r      <= skip_nxt;
      hp_r        <= hp_nxt;
      commas_r    <= commas_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      field_r     <= field_nxt;
      frac_r      <= frac_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      row_open_r  <= row_open_nxt;
      last_r      <= last_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    quot_r       <= quot_nxt;
    rem_r        <= rem_nxt;
    div_neg_r    <= div_neg_nxt;
    row_total_r  <= row_total_nxt;
    value_sum_r  <= value_sum_nxt;
    value_mean_r <= value_mean_nxt;
    mean_valid_r <= mean_valid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_row_total  = row_total_r;
  assign out_value_sum  = value_sum_r;
  assign out_value_mean = value_mean_r;
  assign out_mean_valid = mean_valid_r;

endmodule

// ===== sim/csv_column_sum_average_tb.sv =====
`timescale 1ns / 100ps

module csv_column_sum_average_tb;
  import csvcsa_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;

  typedef enum logic [1:0] {
    PH_BEFORE,
    PH_INTEGER,
    PH_FRACTION,
    PH_DONE
  } num_phase_t;

  typedef struct {
    logic [COUNT_WIDTH-1:0]      row_total;
    logic signed [SUM_WIDTH-1:0] value_sum;
    logic signed [SUM_WIDTH-1:0] value_mean;
    logic                        mean_valid;
  } tally_t;

  // Column tally: tracks the text the block has taken and holds the totals it owes
  class column_tally;
    logic [COL_WIDTH-1:0]   col_sel;
    bit                     skip_hdr;
    bit                     in_header;
    logic [COL_WIDTH-1:0]   commas;
    num_phase_t             phase;
    bit                     negative;
    logic [FIELD_WIDTH-1:0] magnitude;
    int                     frac_count;
    longint                 total;
    logic [COUNT_WIDTH-1:0] rows;
    bit                     row_started;
    tally_t                 expected_totals[$];
    int                     errors;

    function new();
      col_sel  = COLUMN_INDEX_RESET;
      skip_hdr = SKIP_HEADER_RESET;
      errors   = 0;
      restart_text();
    endfunction

    function void clear_field();
      commas      = '0;
      phase       = PH_BEFORE;
      negative    = 1'b0;
      magnitude   = '0;
      frac_count  = 0;
      row_started = 1'b0;
    endfunction

    function void restart_text();
      in_header = skip_hdr;
      clear_field();
      total = 0;
      rows  = '0;
    endfunction

    function void load_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
      case (idx)
        REG_COLUMN_INDEX: col_sel = val[COL_WIDTH-1:0];
        REG_SKIP_HEADER: begin
          skip_hdr  = val[0];
          in_header = val[0];
        end
        default: ;
      endcase
    endfunction

    // Shift one decimal digit into the field, hold at the field maximum
    function void push_digit(logic [3:0] d);
      longint unsigned nv;
      nv = longint'(magnitude) * 10 + longint'(d);
      magnitude = (nv > FIELD_MAX) ? FIELD_MAX : nv[FIELD_WIDTH-1:0];
    endfunction

    // Scale the field to full fraction digits and add it to the saturating sum
    function void close_row();
      longint unsigned scaled;
      longint          v;
      longint          smax;
      longint          smin;
      smax = (longint'(1) << (SUM_WIDTH - 1)) - 1;
      smin = -smax - 1;
      scaled = longint'(magnitude);
      for (int i = frac_count; i < FRAC_DIGITS; i++) scaled = scaled * 10;
      if (scaled > FIELD_MAX) scaled = FIELD_MAX;
      v = negative ? -longint'(scaled) : longint'(scaled);
      if (total + v > smax) total = smax;
      else if (total + v < smin) total = smin;
      else total = total + v;
      if (rows != COUNT_MAX) rows = rows + 1'b1;
      clear_field();
    endfunction

    function void take_byte(logic [BYTE_WIDTH-1:0] c, logic last);
      bit              is_digit;
      longint unsigned abs_sum;
      longint unsigned quot;
      longint          mean_v;
      tally_t          r;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      if (in_header) begin
        if (c == CH_NEWLINE) in_header = 1'b0;
      end else if (c == CH_NEWLINE) begin
        close_row();
      end else begin
        row_started = 1'b1;
        if (c == CH_COMMA) begin
          if (commas == col_sel) phase = PH_DONE;
          if (commas != COMMAS_MAX) commas = commas + 1'b1;
        end else if (commas == col_sel && phase != PH_DONE) begin
          // Number syntax: blanks, sign, integer digits, point, fraction digits
          case (phase)
            PH_BEFORE: begin
              if (c != CH_SPACE && c != CH_TAB) begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                  negative = (c == CH_MINUS);
                  phase    = PH_INTEGER;
                end else if (is_digit) begin
                  push_digit(c[3:0]);
                  phase = PH_INTEGER;
                end else if (c == CH_POINT) begin
                  phase = PH_FRACTION;
                end else begin
                  phase = PH_DONE;
                end
              end
            end
            PH_INTEGER: begin
              if (is_digit) push_digit(c[3:0]);
              else if (c == CH_POINT) phase = PH_FRACTION;
              else phase = PH_DONE;
            end
            PH_FRACTION: begin
              if (is_digit) begin
                // drop fraction digits past the fixed-point precision
                if (frac_count < FRAC_DIGITS) begin
                  push_digit(c[3:0]);
                  frac_count++;
                end
              end else begin
                phase = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      if (last) begin
        if (row_started) close_row();
        mean_v = 0;
        if (rows != 0) begin
          abs_sum = (total < 0) ? longint'(-total) : longint'(total);
          quot    = abs_sum / longint'(rows);
          mean_v  = (total < 0) ? -longint'(quot) : longint'(quot);
        end
        r.row_total  = rows;
        r.value_sum  = total[SUM_WIDTH-1:0];
        r.value_mean = mean_v[SUM_WIDTH-1:0];
        r.mean_valid = (rows != 0);
        expected_totals.push_back(r);
        restart_text();
      end
    endfunction

    function void check_totals(logic [COUNT_WIDTH-1:0] row_total,
                               logic signed [SUM_WIDTH-1:0] value_sum,
                               logic signed [SUM_WIDTH-1:0] value_mean,
                               logic mean_valid);
      tally_t e;
      if (expected_totals.size() == 0) begin
        $error("unexpected result: row_total %0d value_sum %0d", row_total, value_sum);
        errors++;
        return;
      end
      e = expected_totals.pop_front();
      if (row_total !== e.row_total) begin
        $error("row_total: expected %0d, actual %0d", e.row_total, row_total);
        errors++;
      end
      if (value_sum !== e.value_sum) begin
        $error("value_sum: expected %0d, actual %0d", e.value_sum, value_sum);
        errors++;
      end
      if (value_mean !== e.value_mean) begin
        $error("value_mean: expected %0d, actual %0d", e.value_mean, value_mean);
        errors++;
      end
      if (mean_valid !== e.mean_valid) begin
        $error("mean_valid: expected %0b, actual %0b", e.mean_valid, mean_valid);
        errors++;
      end
    endfunction

    function int pending();
      return expected_totals.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_gaps = 1'b0;

  logic [BYTE_WIDTH-1:0] text_buf[$];
  column_tally           tally = new();

  csvcsa_in_if  in_ch();
  csvcsa_out_if out_ch();
  csvcsa_cfg_if cfg_ch();

  csv_column_sum_average u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hold a cycle cap on the whole run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("csv_column_sum_average: mismatch");
    $finish;
  end

  // Stall the result side at random, except in the gap-free stretch
  always @(posedge clk) begin
    out_ch.ready <= no_gaps || ($urandom_range(99) >= 23);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) tally.load_reg(cfg_ch.index, cfg_ch.data);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) tally.take_byte(in_ch.text_byte, in_ch.end_of_text);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tally.check_totals(out_ch.row_total, out_ch.value_sum, out_ch.value_mean,
                         out_ch.mean_valid);
    end
  end

  // Byte of any kind, leaning toward the characters the parser reacts to
  function automatic logic [BYTE_WIDTH-1:0] noisy_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return BYTE_WIDTH'($urandom_range(255));
    if (pick < 55) return CH_COMMA;
    if (pick < 70) return CH_NEWLINE;
    if (pick < 90) return CH_ZERO + BYTE_WIDTH'($urandom_range(9));
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_PLUS;
      2: return CH_MINUS;
      3: return CH_POINT;
      default: return CH_TAB;
    endcase
  endfunction

  // Short field of arbitrary bytes that keeps the row structure intact
  function automatic void add_filler();
    logic [BYTE_WIDTH-1:0] b;
    repeat ($urandom_range(0, 3)) begin
      b = BYTE_WIDTH'($urandom_range(255));
      if (b == CH_COMMA || b == CH_NEWLINE) b = "x";
      text_buf.push_back(b);
    end
  endfunction

  function automatic void add_number();
    int n;
    repeat ($urandom_range(0, 2)) text_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(3))
      0: text_buf.push_back(CH_PLUS);
      1: text_buf.push_back(CH_MINUS);
      default: ;
    endcase
    // mostly short integers, now and then enough digits to hit the field limit
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
    repeat (n) text_buf.push_back(CH_ZERO + BYTE_WIDTH'($urandom_range(9)));
    if ($urandom_range(99) < 60) begin
      text_buf.push_back(CH_POINT);
      repeat ($urandom_range(0, 5)) text_buf.push_back(CH_ZERO + BYTE_WIDTH'($urandom_range(9)));
    end
    if ($urandom_range(99) < 15) add_filler();
  endfunction

  function automatic void add_row(int col);
    int nf;
    nf = ($urandom_range(9) == 0) ? $urandom_range(0, col) : col + 1 + $urandom_range(0, 1);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) text_buf.push_back(CH_COMMA);
      if (f == col && $urandom_range(9) != 0) add_number();
      else add_filler();
    end
    text_buf.push_back(CH_NEWLINE);
  endfunction

  // Mostly well-formed text with random content; the rest raw noise
  function automatic void build_text(int col, bit skip);
    text_buf.delete();
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 20)) text_buf.push_back(noisy_byte());
    end else begin
      if (skip && $urandom_range(9) != 0) begin
        add_filler();
        text_buf.push_back(CH_NEWLINE);
      end
      repeat ((col > 6) ? $urandom_range(1, 2) : $urandom_range(1, 5)) add_row(col);
      if ($urandom_range(99) < 30 && text_buf.size() > 1) void'(text_buf.pop_back());
    end
    if (text_buf.size() == 0) text_buf.push_back(noisy_byte());
  endfunction

  // Send every byte of the buffer, end_of_text on the last one
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      while (!no_gaps && $urandom_range(99) < 23) begin
        in_ch.valid       <= 1'b0;
        in_ch.text_byte   <= BYTE_WIDTH'($urandom);
        in_ch.end_of_text <= 1'($urandom);
        @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.text_byte   <= text_buf[i];
      in_ch.end_of_text <= (i == text_buf.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Wait for every owed result, then let the divider and commit logic drain
  task automatic settle();
    while (tally.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [COL_WIDTH-1:0] col, input bit skip);
    logic [CFG_DATA_WIDTH-1:0] word;
    settle();
    word = CFG_DATA_WIDTH'($urandom);
    word[COL_WIDTH-1:0] = col;
    cfg_write(REG_COLUMN_INDEX, word);
    word = CFG_DATA_WIDTH'($urandom);
    word[0] = skip;
    cfg_write(REG_SKIP_HEADER, word);
  endtask

  initial begin
    int                   phase;
    int                   random_bytes;
    logic [COL_WIDTH-1:0] col;
    bit                   skip;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= '0;
    in_ch.end_of_text <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_COLUMN_INDEX;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: header skipped, field after two commas, last line unterminated
    send_string("a\n,,9");
    // Sign, extra fraction digits, non-numeric row, blanks, empty line
    configure(4'd0, 1'b0);
    send_string("-1.2345\n");
    send_string("\377\n +7");
    send_string("\n");
    // Text ending in the header, then a bare fraction
    configure(4'd1, 1'b1);
    send_string("h\n");
    send_string("x\n,.5");

    phase        = 0;
    random_bytes = 0;
    while (random_bytes < 850) begin
      case (phase)
        0: begin col = 4'd0;  skip = 1'b0; end
        1: begin col = 4'd15; skip = 1'b1; end
        2: begin col = 4'd15; skip = 1'b0; end
        3: begin col = 4'd0;  skip = 1'b1; end
        default: begin
          col  = ($urandom_range(9) < 7) ? COL_WIDTH'($urandom_range(0, 3))
                                         : COL_WIDTH'($urandom_range(0, 15));
          skip = 1'($urandom);
        end
      endcase
      configure(col, skip);
      no_gaps = (phase == 2);
      repeat ((phase == 2) ? 6 : $urandom_range(3, 6)) begin
        build_text(col, skip);
        random_bytes += text_buf.size();
        send_text();
      end
      no_gaps = 1'b0;
      phase++;
    end

    settle();
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("csv_column_sum_average: match");
    end else begin
      $display("csv_column_sum_average: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csvcsa_pkg.sv
rtl/csvcsa_if.sv
rtl/csvcsa_ctrl.sv
rtl/csvcsa_dp.sv
rtl/csv_column_sum_average.sv
sim/csv_column_sum_average_tb.sv
